// ===== hdl/array_linked_list_manager_defines.svh =====
// Assertion macros shared by the checker of the linked list manager.
// Depends on nothing; files that assert take it in with an include.
`ifndef ARRAY_LINKED_LIST_MANAGER_DEFINES_SVH
`define ARRAY_LINKED_LIST_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ALLM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ALLM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/allm_pkg.sv =====
// Shared constants, command codes and types of the linked list manager.
// Depends on nothing; every file but the macros header refers to it by scoped names.
package allm_pkg;

  localparam int CAPACITY = 16;
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEAD_INS = 3'd0,
    CMD_TAIL_INS = 3'd1,
    CMD_ORD_INS  = 3'd2,
    CMD_HEAD_REM = 3'd3,
    CMD_TAIL_REM = 3'd4,
    CMD_VAL_REM  = 3'd5,
    CMD_SEARCH   = 3'd6
  } allm_cmd_t;

  // Write enables of the node store, one per memory.
  typedef struct packed {
    logic value_we;
    logic link_we;
  } allm_wr_en_t;

endpackage

// ===== hdl/allm_cmd_if.sv =====
// Command channel of the linked list manager: valid/ready plus payload.
// Depends on allm_pkg for the field widths.
interface allm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [allm_pkg::CMD_W-1:0]          command;
  logic signed [allm_pkg::DATA_W-1:0]  data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink (input valid, input command, input data_in, output ready);
endinterface

// ===== hdl/allm_rsp_if.sv =====
// Result channel of the linked list manager: valid/ready plus payload.
// Depends on allm_pkg for the field widths.
interface allm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [allm_pkg::DATA_W-1:0]  data_out;

  modport source (output valid, output ok, output data_out, input ready);
  modport sink (input valid, input ok, input data_out, output ready);
endinterface

// ===== hdl/array_linked_list_manager.sv =====
// Throughput: one command at a time; walks read one node per cycle through the
// node store's single read port.
// Reset: synchronous; the list is empty and all nodes are free at once, with
// no clearing pass, because the store's fill mark supplies the reset links.
module array_linked_list_manager #(
  parameter int CAPACITY = allm_pkg::CAPACITY
) (
  input logic        clk,
  input logic        rst,
  allm_cmd_if.sink   cmd,
  allm_rsp_if.source rsp
);

  // Index width: one code beyond the last node marks the end of a chain.
  localparam int IW = $clog2(CAPACITY + 1);

  // Node store port signals. The sequencer owns every access; the store only
  // holds the values and links and resolves links of never-used nodes.
  logic                               rd_en;
  logic [IW-1:0]                      rd_addr;
  logic signed [allm_pkg::DATA_W-1:0] rd_value;
  logic [IW-1:0]                      rd_link;
  allm_pkg::allm_wr_en_t              wr_en;
  logic [IW-1:0]                      wr_addr;
  logic signed [allm_pkg::DATA_W-1:0] wr_value;
  logic [IW-1:0]                      wr_link;

  // The sequencer accepts a transaction only when idle. Its result goes to an
  // output register, so the next command can be taken while the previous
  // result still waits for the consumer.
  allm_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_value (wr_value),
    .wr_link  (wr_link)
  );

  // Value and link memories with registered reads.
  allm_node_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_value (wr_value),
    .wr_link  (wr_link)
  );

endmodule

// ===== hdl/allm_node_store.sv =====
// Node store: value and link memories with one registered read port each.
// Depends on allm_pkg. Links of never-written entries read as index plus one.
module allm_node_store #(
  parameter int CAPACITY = allm_pkg::CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rd_en,
  input  logic [$clog2(CAPACITY+1)-1:0]      rd_addr,
  output logic signed [allm_pkg::DATA_W-1:0] rd_value,
  output logic [$clog2(CAPACITY+1)-1:0]      rd_link,
  input  allm_pkg::allm_wr_en_t              wr_en,
  input  logic [$clog2(CAPACITY+1)-1:0]      wr_addr,
  input  logic signed [allm_pkg::DATA_W-1:0] wr_value,
  input  logic [$clog2(CAPACITY+1)-1:0]      wr_link
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [allm_pkg::DATA_W-1:0] value_mem [0:CAPACITY-1];
  logic [IW-1:0]                      link_mem  [0:CAPACITY-1];

  // Entries are handed out in ascending order the first time, so every entry
  // at or above the fill mark still holds its reset link.
  logic [IW-1:0] fill;
  logic [IW-1:0] link_q;
  logic [IW-1:0] fresh_link_q;
  logic          fresh_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value     <= value_mem[rd_addr[AW-1:0]];
      link_q       <= link_mem[rd_addr[AW-1:0]];
      fresh_q      <= (rd_addr >= fill);
      fresh_link_q <= rd_addr + IW'(1);
    end
    if (wr_en.value_we) begin
      value_mem[wr_addr[AW-1:0]] <= wr_value;
    end
    if (wr_en.link_we) begin
      link_mem[wr_addr[AW-1:0]] <= wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en.link_we && (wr_addr == fill)) begin
      fill <= fill + IW'(1);
    end
  end

  assign rd_link = fresh_q ? fresh_link_q : link_q;

endmodule

// ===== hdl/allm_ctrl.sv =====
// Command sequencer: walks the list through the node store and writes back.
// Depends on allm_pkg, allm_cmd_if, allm_rsp_if and the node store ports.
module allm_ctrl #(
  parameter int CAPACITY = allm_pkg::CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  allm_cmd_if.sink                           cmd,
  allm_rsp_if.source                         rsp,
  output logic                               rd_en,
  output logic [$clog2(CAPACITY+1)-1:0]      rd_addr,
  input  logic signed [allm_pkg::DATA_W-1:0] rd_value,
  input  logic [$clog2(CAPACITY+1)-1:0]      rd_link,
  output allm_pkg::allm_wr_en_t              wr_en,
  output logic [$clog2(CAPACITY+1)-1:0]      wr_addr,
  output logic signed [allm_pkg::DATA_W-1:0] wr_value,
  output logic [$clog2(CAPACITY+1)-1:0]      wr_link
);

  localparam int            IW  = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] END = IW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_WALK, S_SCAN, S_INS_NODE, S_INS_PREV, S_RELINK, S_DONE
  } state_t;

  state_t                             state;
  logic [allm_pkg::CMD_W-1:0]         cmd_q;
  logic signed [allm_pkg::DATA_W-1:0] val_q;
  logic [IW-1:0]                      list_head;
  logic [IW-1:0]                      free_head;
  logic [IW-1:0]                      node;
  logic [IW-1:0]                      prev;
  logic [IW-1:0]                      cur;
  logic [IW-1:0]                      nxt_q;
  logic [IW-1:0]                      steps;
  logic                               ok_q;
  logic signed [allm_pkg::DATA_W-1:0] dout_q;
  logic                               rsp_valid;
  logic                               rsp_ok;
  logic signed [allm_pkg::DATA_W-1:0] rsp_data;

  logic [IW-1:0] nxt;
  logic [IW-1:0] steps_inc;
  logic          in_is_ins;
  logic          in_is_scan;
  logic          walk_stop;
  logic          walk_more;
  logic          scan_hit;
  logic          scan_more;

  assign cmd.ready    = (state == S_IDLE) && !rst;
  assign rsp.valid    = rsp_valid;
  assign rsp.ok       = rsp_ok;
  assign rsp.data_out = rsp_data;

  always_comb begin
    nxt       = (rd_link < END) ? rd_link : END;
    steps_inc = steps + IW'(1);
    in_is_ins = (cmd.command == allm_pkg::CMD_HEAD_INS) ||
                (cmd.command == allm_pkg::CMD_TAIL_INS) ||
                (cmd.command == allm_pkg::CMD_ORD_INS);
    in_is_scan = (cmd.command == allm_pkg::CMD_HEAD_REM) ||
                 (cmd.command == allm_pkg::CMD_TAIL_REM) ||
                 (cmd.command == allm_pkg::CMD_VAL_REM) ||
                 (cmd.command == allm_pkg::CMD_SEARCH);
    // The ordered insert stops in front of the first value not below the new one.
    walk_stop = (cmd_q == allm_pkg::CMD_ORD_INS) && (rd_value >= val_q);
    walk_more = !walk_stop && (nxt != END) && (steps_inc != END);
    unique case (cmd_q)
      allm_pkg::CMD_HEAD_REM: scan_hit = 1'b1;
      allm_pkg::CMD_TAIL_REM: scan_hit = (nxt == END) || (steps == END);
      allm_pkg::CMD_VAL_REM,
      allm_pkg::CMD_SEARCH:   scan_hit = (rd_value == val_q);
      default:                scan_hit = 1'b0;
    endcase
    scan_more = !scan_hit && ((cmd_q == allm_pkg::CMD_TAIL_REM) ||
                              ((nxt != END) && (steps_inc != END)));
  end

  // Memory port control. Reads and writes never touch the same entry in one
  // cycle, so the store needs no bypass.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = list_head;
    wr_en    = '0;
    wr_addr  = cur;
    wr_value = val_q;
    wr_link  = free_head;
    unique case (state)
      S_IDLE: begin
        rd_addr = in_is_ins ? free_head : list_head;
        rd_en   = cmd.valid && (rd_addr != END);
      end
      S_ALLOC: begin
        rd_addr = list_head;
        rd_en   = (cmd_q != allm_pkg::CMD_HEAD_INS) && (list_head != END);
      end
      S_WALK: begin
        rd_addr = nxt;
        rd_en   = walk_more;
      end
      S_SCAN: begin
        rd_addr = nxt;
        rd_en   = scan_more;
        if (scan_hit && (cmd_q != allm_pkg::CMD_SEARCH)) begin
          wr_en.link_we = 1'b1;
          wr_addr       = cur;
          wr_link       = free_head;
        end
      end
      S_INS_NODE: begin
        wr_en.value_we = 1'b1;
        wr_en.link_we  = 1'b1;
        wr_addr        = node;
        wr_link        = cur;
      end
      S_INS_PREV: begin
        wr_en.link_we = 1'b1;
        wr_addr       = prev;
        wr_link       = node;
      end
      S_RELINK: begin
        wr_en.link_we = 1'b1;
        wr_addr       = prev;
        wr_link       = nxt_q;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= END;
      free_head <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In S_DONE the result load below owns the valid flag.
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q  <= cmd.command;
            val_q  <= cmd.data_in;
            ok_q   <= 1'b0;
            dout_q <= '0;
            prev   <= END;
            cur    <= list_head;
            steps  <= '0;
            node   <= free_head;
            if (in_is_ins) begin
              state <= (free_head == END) ? S_DONE : S_ALLOC;
            end else if (in_is_scan) begin
              state <= (list_head == END) ? S_DONE : S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ALLOC: begin
          free_head <= nxt;
          if ((cmd_q == allm_pkg::CMD_HEAD_INS) || (list_head == END)) begin
            state <= S_INS_NODE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            state <= S_INS_NODE;
          end else begin
            prev  <= cur;
            cur   <= nxt;
            steps <= steps_inc;
            if (!walk_more) begin
              state <= S_INS_NODE;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            ok_q <= 1'b1;
            if ((cmd_q == allm_pkg::CMD_HEAD_REM) || (cmd_q == allm_pkg::CMD_TAIL_REM)) begin
              dout_q <= rd_value;
            end
            if (cmd_q == allm_pkg::CMD_SEARCH) begin
              state <= S_DONE;
            end else begin
              free_head <= cur;
              nxt_q     <= nxt;
              if (prev == END) begin
                list_head <= nxt;
                state     <= S_DONE;
              end else begin
                state <= S_RELINK;
              end
            end
          end else begin
            prev  <= cur;
            cur   <= nxt;
            steps <= steps_inc;
            if (!scan_more) begin
              state <= S_DONE;
            end
          end
        end
        S_INS_NODE: begin
          ok_q <= 1'b1;
          if (prev == END) begin
            list_head <= node;
            state     <= S_DONE;
          end else begin
            state <= S_INS_PREV;
          end
        end
        S_INS_PREV: begin
          state <= S_DONE;
        end
        S_RELINK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_ok    <= ok_q;
            rsp_data  <= dout_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/allm_checker.sv =====
// Port-level checker of the linked list manager and its bind statement.
// Depends on allm_pkg and the assertion macros header.
`include "array_linked_list_manager_defines.svh"

module allm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               rsp_ok,
  input logic signed [allm_pkg::DATA_W-1:0] rsp_data_out
);

  logic [1:0] pending;
  logic       cmd_fire;
  logic       rsp_fire;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd_fire && !rsp_fire) begin
      pending <= pending + 2'd1;
    end else if (rsp_fire && !cmd_fire) begin
      pending <= pending - 2'd1;
    end
  end

  `ALLM_ASSERT_IMP(a_accept_room, clk, rst, cmd_fire, pending <= 2'd1, "command taken with two outstanding")
  `ALLM_ASSERT_IMP(a_no_phantom, clk, rst, rsp_valid, pending != 2'd0, "result with no command outstanding")
  `ALLM_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_data_out), "stalled result changed")
  `ALLM_ASSERT_IMP(a_fail_zero, clk, rst, rsp_valid && !rsp_ok, rsp_data_out == '0, "failed command returned data")

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_ok       (rsp.ok),
  .rsp_data_out (rsp.data_out)
);

// ===== tb/allm_list_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the linked list manager: mirrors the node store and both chains.
// Depends on allm_pkg and on the allm_cmd_if and allm_rsp_if interfaces.
module allm_list_checker (
  input  logic clk,
  input  logic rst,
  allm_cmd_if  cmd,
  allm_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int N = allm_pkg::CAPACITY;

  typedef struct packed {
    logic                               ok;
    logic signed [allm_pkg::DATA_W-1:0] data_out;
  } list_result_t;

  // Mirror of the node store; position N stands for the list head pointer.
  logic signed [allm_pkg::DATA_W-1:0] slot_value [N];
  int                                 slot_next  [N];
  int                                 used_first;
  int                                 spare_first;
  list_result_t                       expected_q [$];

  function automatic int follow(int pos);
    int n;
    n = (pos < N) ? slot_next[pos] : used_first;
    return (n < N) ? n : N;
  endfunction

  function automatic void relink(int pos, int target);
    if (pos < N) begin
      slot_next[pos] = target;
    end else begin
      used_first = target;
    end
  endfunction

  // Unlinks node (which follows pos) and pushes it onto the free chain.
  function automatic void free_slot(int pos, int node);
    relink(pos, follow(node));
    slot_next[node] = spare_first;
    spare_first = node;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < N; i++) begin
      slot_value[i] = '0;
      slot_next[i] = i + 1;
    end
    used_first = N;
    spare_first = 0;
  endfunction

  function automatic list_result_t run_command(logic [allm_pkg::CMD_W-1:0] op,
                                               logic signed [allm_pkg::DATA_W-1:0] arg);
    list_result_t res;
    int prev;
    int cur;
    int node;
    int steps;
    res = '0;
    prev = N;
    steps = 0;
    case (op)
      allm_pkg::CMD_HEAD_INS, allm_pkg::CMD_TAIL_INS, allm_pkg::CMD_ORD_INS: begin
        node = spare_first;
        if (node < N) begin
          spare_first = (slot_next[node] < N) ? slot_next[node] : N;
          cur = follow(prev);
          // Ordered insert stops at the first node not less than the new value.
          while (op != allm_pkg::CMD_HEAD_INS && cur != N && steps < N &&
                 !(op == allm_pkg::CMD_ORD_INS && slot_value[cur] >= arg)) begin
            prev = cur;
            cur = follow(cur);
            steps++;
          end
          slot_value[node] = arg;
          slot_next[node] = cur;
          relink(prev, node);
          res.ok = 1'b1;
        end
      end
      allm_pkg::CMD_HEAD_REM, allm_pkg::CMD_TAIL_REM: begin
        cur = follow(prev);
        if (cur != N) begin
          while (op == allm_pkg::CMD_TAIL_REM && follow(cur) != N && steps < N) begin
            prev = cur;
            cur = follow(cur);
            steps++;
          end
          res.data_out = slot_value[cur];
          free_slot(prev, cur);
          res.ok = 1'b1;
        end
      end
      allm_pkg::CMD_VAL_REM, allm_pkg::CMD_SEARCH: begin
        cur = follow(prev);
        while (!res.ok && cur != N && steps < N) begin
          if (slot_value[cur] == arg) begin
            if (op == allm_pkg::CMD_VAL_REM) free_slot(prev, cur);
            res.ok = 1'b1;
          end else begin
            prev = cur;
            cur = follow(cur);
            steps++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (rst) begin
      clear_store();
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got ok=%0b data_out=%0d",
                   $time, rsp.ok, rsp.data_out);
        end else begin
          want = expected_q.pop_front();
          if (rsp.ok !== want.ok || rsp.data_out !== want.data_out) begin
            mismatches++;
            $display("%0t: mismatch: expected ok=%0b data_out=%0d, got ok=%0b data_out=%0d",
                     $time, want.ok, want.data_out, rsp.ok, rsp.data_out);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(run_command(cmd.command, cmd.data_in));
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/tb_array_linked_list_manager.sv =====
`timescale 1ns / 1ps
// Top of the linked list manager testbench: clock, reset, stimulus and verdict.
// Depends on allm_pkg, both channel interfaces, the block and allm_list_checker.
module tb_array_linked_list_manager;

  // The command field has one code that the block does not use; it must be
  // answered with a failed, zero result and leave the list alone.
  localparam logic [allm_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int PHASE_ITEMS = 400;
  localparam int LIMIT       = 400000;
  localparam int SETTLE      = allm_pkg::CAPACITY + 8;
  localparam int BIAS_SPAN   = 40;

  localparam logic signed [allm_pkg::DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic signed [allm_pkg::DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  logic clk;
  logic rst;
  int   send_gap_pct = 0;
  int   stall_pct    = 0;
  int   cycles       = 0;
  int   mismatches;
  int   outstanding;

  allm_cmd_if cmd_ch ();
  allm_rsp_if rsp_ch ();

  array_linked_list_manager dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // The checker watches both channels, keeps the expected results and counts
  // mismatches; this module only drives the block and decides the outcome.
  allm_list_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: ready is redrawn at every falling edge, so stalls can land on
  // any cycle of a command's walk, not only while a result is waiting.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a result that never comes ends up here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_array_linked_list_manager failed");
      $finish;
    end
  end

  // Presents one command transaction and returns at the edge that takes it.
  // Valid stays high from one transaction to the next unless a gap is drawn,
  // so back-to-back commands never see valid dropped and raised in one step.
  task automatic issue(input logic [allm_pkg::CMD_W-1:0] op,
                       input logic signed [allm_pkg::DATA_W-1:0] arg);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.data_in <= arg;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Holds the command side idle until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [allm_pkg::CMD_W-1:0]         op;
    logic signed [allm_pkg::DATA_W-1:0] arg;
    int                                 r;
    bit                                 filling;

    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = allm_pkg::CMD_SEARCH;
    cmd_ch.data_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty list must refuse every remove and search.
    issue(allm_pkg::CMD_SEARCH, '0);
    issue(allm_pkg::CMD_HEAD_REM, '0);
    issue(allm_pkg::CMD_TAIL_REM, '0);
    issue(allm_pkg::CMD_VAL_REM, 32'sd5);
    issue(CMD_UNUSED, MOST_POS);
    // Ordered inserts at the signed extremes; the second zero must land in
    // front of the first one.
    issue(allm_pkg::CMD_ORD_INS, MOST_POS);
    issue(allm_pkg::CMD_ORD_INS, MOST_NEG);
    issue(allm_pkg::CMD_ORD_INS, '0);
    issue(allm_pkg::CMD_ORD_INS, -32'sd1);
    issue(allm_pkg::CMD_ORD_INS, '0);
    issue(allm_pkg::CMD_HEAD_INS, 32'h5555_5555);
    issue(allm_pkg::CMD_TAIL_INS, 32'hAAAA_AAAA);
    // Head inserts fill the store while keeping the alternating pattern at
    // the tail; one more insert must then be refused as the store is full.
    repeat (allm_pkg::CAPACITY - 7) issue(allm_pkg::CMD_HEAD_INS, $urandom());
    issue(allm_pkg::CMD_ORD_INS, 32'sd1);
    issue(allm_pkg::CMD_SEARCH, MOST_POS);
    // Removing by value has to reach the very last node of a full list.
    issue(allm_pkg::CMD_VAL_REM, 32'hAAAA_AAAA);
    issue(allm_pkg::CMD_TAIL_REM, '0);
    issue(allm_pkg::CMD_HEAD_REM, '0);
    drain();

    // Random part in four idling phases. Within each phase the mix swings
    // between filling and emptying the list, so full and empty states recur.
    // Half of the values come from a narrow pool so that searches, removals and
    // equal keys hit often; the rest are wide random values and extremes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 57; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 57; end
        default: begin send_gap_pct = 26; stall_pct = 26; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        filling = ((k / BIAS_SPAN) % 2) == 0;
        r = $urandom_range(99);
        if (r == 0) begin
          op = CMD_UNUSED;
        end else if (r < (filling ? 60 : 25)) begin
          case ($urandom_range(2))
            0: op = allm_pkg::CMD_HEAD_INS;
            1: op = allm_pkg::CMD_TAIL_INS;
            default: op = allm_pkg::CMD_ORD_INS;
          endcase
        end else if (r < (filling ? 80 : 45)) begin
          op = allm_pkg::CMD_SEARCH;
        end else begin
          case ($urandom_range(2))
            0: op = allm_pkg::CMD_HEAD_REM;
            1: op = allm_pkg::CMD_TAIL_REM;
            default: op = allm_pkg::CMD_VAL_REM;
          endcase
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4: arg = $signed({29'd0, 3'($urandom_range(7))}) - 32'sd3;
          5, 6, 7:       arg = $urandom();
          8:             arg = MOST_NEG;
          default:       arg = MOST_POS;
        endcase
        issue(op, arg);
      end
      // Let the block run dry between phases before the next idling pattern.
      drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_array_linked_list_manager passed");
    end else begin
      $display("tb_array_linked_list_manager failed");
    end
    $finish;
  end

endmodule
